// ----- sv/sialu_pkg.sv -----
// Shared types for the signed integer ALU: opcodes, controller states, command and status words.
package sialu_pkg;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_RUN    = 2'd1,
        ST_FINISH = 2'd2
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;    // capture operands, set up the first step
        logic step;    // one shift-add or one restoring-divide step
        logic finish;  // apply sign, write the output word register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic iterative;  // captured opcode is multiply or divide
    } status_t;

endpackage

// ----- sv/signed_integer_alu_mul_div.sv -----
// Top level of the signed integer ALU: add, subtract, multiply and divide on signed words.
//
// Usage:
//   Input word (s_opcode, s_operand_a, s_operand_b) is taken with s_valid/s_ready;
//   the result word (m_result, m_divide_by_zero) leaves with m_valid/m_ready.
//   Opcodes: add, subtract, multiply (low DATA_WIDTH bits), divide (truncated toward zero).
//   Multiply runs shift-and-add on operand magnitudes, divide runs restoring
//   long division; both then apply the sign. A zero divisor raises
//   m_divide_by_zero and yields an all-ones quotient magnitude with the sign applied.
// Sequence:
//   Multiply and divide go from acceptance through one load step, DATA_WIDTH
//   iteration steps of the shared shift/subtract unit and one sign fix-up
//   step to a valid result; add and subtract skip the iteration steps.
//   One word is in flight at a time, so a new word is taken only after the
//   previous word's result has been written to the output register.
// Reset:
//   aresetn (synchronous, active low) returns the controller to idle and drops m_valid.
// Stall:
//   A finished result waits in the output register; a new word may be taken and
//   computed meanwhile, and its result holds in the datapath until the register frees.
module signed_integer_alu_mul_div #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_opcode,
    input  logic signed [DATA_WIDTH-1:0] s_operand_a,
    input  logic signed [DATA_WIDTH-1:0] s_operand_b,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [DATA_WIDTH-1:0] m_result,
    output logic                         m_divide_by_zero
);

    sialu_pkg::cmd_t    cmd;
    sialu_pkg::status_t sts;
    logic [DATA_WIDTH-1:0] result_bits;

    // Sequence the word: load, iterate, hand off
    sialu_ctrl #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Operand, accumulator and output registers
    sialu_dp #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .aclk       (aclk),
        .cmd        (cmd),
        .sts        (sts),
        .in_opcode  (s_opcode),
        .in_a       (s_operand_a),
        .in_b       (s_operand_b),
        .out_result (result_bits),
        .out_dz     (m_divide_by_zero)
    );

    assign m_result = $signed(result_bits);

endmodule

// ----- sv/sialu_dp.sv -----
// Datapath of the signed integer ALU: operand, accumulator and output word registers.
module sialu_dp #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  aclk,
    input  sialu_pkg::cmd_t       cmd,
    output sialu_pkg::status_t    sts,
    input  logic [1:0]            in_opcode,
    input  logic [DATA_WIDTH-1:0] in_a,
    input  logic [DATA_WIDTH-1:0] in_b,
    output logic [DATA_WIDTH-1:0] out_result,
    output logic                  out_dz
);
    localparam int DW = DATA_WIDTH;

    sialu_pkg::op_t  op_reg, op_next, in_op;
    logic            neg_reg, neg_next;
    logic [DW-1:0]   a_reg, a_next;     // multiplier (shifts right) or dividend/quotient
    logic [DW-1:0]   b_reg, b_next;     // multiplicand (shifts left) or divisor
    logic [DW-1:0]   acc_reg, acc_next; // product, remainder, or add/sub result
    logic [DW-1:0]   res_reg, res_next;
    logic            dz_reg, dz_next;
    logic            dz_out_reg, dz_out_next; // flag held beside the output word

    logic [DW-1:0]   a_mag, b_mag, mag, neg_mag;
    logic [DW:0]     shifted;
    logic [DW+1:0]   diff;
    logic            take;

    always_comb begin
        in_op   = sialu_pkg::op_t'(in_opcode);
        a_mag   = in_a[DW-1] ? (DW'(0) - in_a) : in_a;
        b_mag   = in_b[DW-1] ? (DW'(0) - in_b) : in_b;
        // restoring divide trial subtract; top bit is the borrow
        shifted = {acc_reg, a_reg[DW-1]};
        diff    = {1'b0, shifted} - {2'b00, b_reg};
        take    = !diff[DW+1];
        mag     = (op_reg == sialu_pkg::OP_DIV) ? a_reg : acc_reg;
        neg_mag = DW'(0) - mag;
    end

    always_comb begin
        op_next     = op_reg;
        neg_next    = neg_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        acc_next    = acc_reg;
        res_next    = res_reg;
        dz_next     = dz_reg;
        dz_out_next = dz_out_reg;
        if (cmd.load) begin
            op_next  = in_op;
            neg_next = in_a[DW-1] ^ in_b[DW-1];
            a_next   = a_mag;
            b_next   = b_mag;
            dz_next  = (in_op == sialu_pkg::OP_DIV) && (in_b == '0);
            case (in_op)
                sialu_pkg::OP_ADD: acc_next = in_a + in_b;
                sialu_pkg::OP_SUB: acc_next = in_a - in_b;
                default:           acc_next = '0;
            endcase
        end else if (cmd.step) begin
            if (op_reg == sialu_pkg::OP_MUL) begin
                if (a_reg[0]) begin
                    acc_next = acc_reg + b_reg;
                end
                a_next = a_reg >> 1;
                b_next = b_reg << 1;
            end else begin
                acc_next = take ? diff[DW-1:0] : shifted[DW-1:0];
                a_next   = {a_reg[DW-2:0], take};
            end
        end
        if (cmd.finish) begin
            dz_out_next = dz_reg;
            if (((op_reg == sialu_pkg::OP_MUL) || (op_reg == sialu_pkg::OP_DIV)) && neg_reg) begin
                res_next = neg_mag;
            end else begin
                res_next = mag;
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        neg_reg    <= neg_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        acc_reg    <= acc_next;
        res_reg    <= res_next;
        dz_reg     <= dz_next;
        dz_out_reg <= dz_out_next;
    end

    assign sts.iterative = (op_reg == sialu_pkg::OP_MUL) || (op_reg == sialu_pkg::OP_DIV);
    assign out_result    = res_reg;
    assign out_dz        = dz_out_reg;

endmodule

// ----- sv/sialu_ctrl.sv -----
// Controller of the signed integer ALU: sequences load, iteration steps and output handoff.
module sialu_ctrl #(
    parameter int DATA_WIDTH = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  sialu_pkg::status_t sts,
    output sialu_pkg::cmd_t    cmd
);
    localparam int CNT_W = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DATA_WIDTH - 1);

    sialu_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              valid_reg, valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sialu_pkg::ST_IDLE;
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        valid_next = valid_reg && !m_ready;
        case (state_reg)
            sialu_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    cnt_next   = LAST_STEP;
                    state_next = sialu_pkg::ST_RUN;
                end
            end
            sialu_pkg::ST_RUN: begin
                if (!sts.iterative) begin
                    state_next = sialu_pkg::ST_FINISH;
                end else begin
                    cmd.step = 1'b1;
                    if (cnt_reg == '0) begin
                        state_next = sialu_pkg::ST_FINISH;
                    end else begin
                        cnt_next = cnt_reg - 1'b1;
                    end
                end
            end
            sialu_pkg::ST_FINISH: begin
                // hold until the output word register is free or being drained
                if (!valid_reg || m_ready) begin
                    cmd.finish = 1'b1;
                    valid_next = 1'b1;
                    state_next = sialu_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sialu_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid = valid_reg;

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for the signed integer ALU: random and corner words with handshake stalls.
`timescale 1ns / 100ps

module testbench;

    localparam int WIDTH = 32;
    // Length of the final flush after the drain, with margin for stray result words.
    localparam int FLUSH_CYCLES = WIDTH + 8;
    // Long receiver hold-off: far longer than one word, so the block fills and stalls s_ready.
    localparam int HOLD_CYCLES = 300;
    // Watchdog bound: several times the slowest correct run of roughly 1300 words.
    localparam int CYCLE_LIMIT = 400000;

    localparam logic signed [WIDTH-1:0] INT_MIN = {1'b1, {(WIDTH-1){1'b0}}};
    localparam logic signed [WIDTH-1:0] INT_MAX = {1'b0, {(WIDTH-1){1'b1}}};

    typedef struct {
        logic signed [WIDTH-1:0] result;
        logic                    divide_by_zero;
    } alu_outcome_t;

    // Predicts each result word and holds the ones still in flight, oldest first.
    class alu_ledger;
        alu_outcome_t awaited_results[$];
        int           error_count = 0;

        function alu_outcome_t predict_outcome(sialu_pkg::op_t op, logic signed [WIDTH-1:0] a,
                                               logic signed [WIDTH-1:0] b);
            logic [WIDTH-1:0] mag_a;
            logic [WIDTH-1:0] mag_b;
            logic [WIDTH-1:0] magnitude;
            logic             negative;
            alu_outcome_t     outcome;
            negative = a[WIDTH-1] ^ b[WIDTH-1];
            // Most negative value keeps its bit pattern, read as unsigned 2^(WIDTH-1).
            mag_a = a[WIDTH-1] ? (~a + 1'b1) : a;
            mag_b = b[WIDTH-1] ? (~b + 1'b1) : b;
            outcome.divide_by_zero = 1'b0;
            magnitude = '0;
            case (op)
                sialu_pkg::OP_ADD: outcome.result = a + b;
                sialu_pkg::OP_SUB: outcome.result = a - b;
                sialu_pkg::OP_MUL: begin
                    magnitude = mag_a * mag_b;
                    outcome.result = negative ? (~magnitude + 1'b1) : magnitude;
                end
                default: begin
                    // Zero divisor: every restoring step succeeds, quotient magnitude is all ones.
                    if (mag_b == '0) begin
                        magnitude = '1;
                        outcome.divide_by_zero = 1'b1;
                    end else begin
                        magnitude = mag_a / mag_b;
                    end
                    outcome.result = negative ? (~magnitude + 1'b1) : magnitude;
                end
            endcase
            return outcome;
        endfunction

        function void note_operands(sialu_pkg::op_t op, logic signed [WIDTH-1:0] a,
                                    logic signed [WIDTH-1:0] b);
            awaited_results.push_back(predict_outcome(op, a, b));
        endfunction

        function void check_result(logic signed [WIDTH-1:0] result, logic divide_by_zero);
            alu_outcome_t want;
            if (awaited_results.size() == 0) begin
                $error("unexpected result word: result %0d divide_by_zero %0b",
                       result, divide_by_zero);
                error_count++;
                return;
            end
            want = awaited_results.pop_front();
            if (result !== want.result) begin
                $error("field result: expected %0d (0x%h), actual %0d (0x%h)",
                       want.result, want.result, result, result);
                error_count++;
            end
            if (divide_by_zero !== want.divide_by_zero) begin
                $error("field divide_by_zero: expected %0b, actual %0b",
                       want.divide_by_zero, divide_by_zero);
                error_count++;
            end
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction
    endclass

    // Clock, reset and block ports; every input is known from time zero.
    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic [1:0]              s_opcode = sialu_pkg::OP_ADD;
    logic signed [WIDTH-1:0] s_operand_a = '0;
    logic signed [WIDTH-1:0] s_operand_b = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic signed [WIDTH-1:0] m_result;
    logic                    m_divide_by_zero;

    // Idle percentages per side, changed by the stimulus between phases.
    int         send_idle_pct = 38;
    int         recv_idle_pct = 65;
    logic       hold_request = 1'b0;
    int         hold_left = 0;
    int         cycle_count = 0;
    alu_ledger  ledger;

    signed_integer_alu_mul_div #(
        .DATA_WIDTH(WIDTH)
    ) uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_operand_a     (s_operand_a),
        .s_operand_b     (s_operand_b),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result        (m_result),
        .m_divide_by_zero(m_divide_by_zero)
    );

    always #5 aclk = ~aclk;

    // Watchdog: end the run if the block hangs.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Receiver: pick m_ready at each falling edge. A hold-off request parks
    // m_ready low until the hold_left countdown set here runs out, while the sender keeps offering.
    always @(negedge aclk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready = 1'b0;
        end else begin
            m_ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Sample the result channel at the rising edge; values are the pre-edge ones.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            ledger.check_result(m_result, m_divide_by_zero);
        end
    end

    // Offer one word, starting at a falling edge. Idle random cycles first,
    // then hold valid and payload until the word is taken, then advance to
    // the next falling edge so the next word follows without a valid drop.
    task automatic send_word(input sialu_pkg::op_t op, input logic signed [WIDTH-1:0] a,
                             input logic signed [WIDTH-1:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_opcode = op;
        s_operand_a = a;
        s_operand_b = b;
        do @(posedge aclk); while (!s_ready);
        ledger.note_operands(op, a, b);
        @(negedge aclk);
    endtask

    // Drop valid and wait until every predicted word has come back.
    task automatic wait_for_drain();
        s_valid = 1'b0;
        while (ledger.pending() != 0) @(negedge aclk);
    endtask

    // Operand mix: mostly full-range words, plus small values, corners and
    // words of assorted magnitude so that division gives varied quotients.
    function automatic logic signed [WIDTH-1:0] random_operand();
        logic signed [WIDTH-1:0] corners[5];
        logic signed [WIDTH-1:0] v;
        corners = '{INT_MIN, INT_MAX, '0, 1, -1};
        case ($urandom_range(9))
            5, 6: v = int'($urandom_range(200)) - 100;
            7: v = corners[$urandom_range(4)];
            8: begin
                v = $urandom >> $urandom_range(WIDTH - 1);
                if ($urandom_range(1)) v = -v;
            end
            9: v = $urandom_range(255);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic send_random_words(input int count);
        repeat (count) begin
            send_word(sialu_pkg::op_t'($urandom_range(3)), random_operand(), random_operand());
        end
    endtask

    initial begin
        ledger = new;

        // Hold reset low, then release it at a falling edge.
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed corners: wrap on add/sub, most negative magnitudes,
        // sign handling, zero divisor with both dividend signs, truncation.
        send_word(sialu_pkg::OP_ADD, INT_MAX, INT_MAX);
        send_word(sialu_pkg::OP_ADD, INT_MIN, INT_MIN);
        send_word(sialu_pkg::OP_ADD, -1, 1);
        send_word(sialu_pkg::OP_SUB, INT_MIN, 1);
        send_word(sialu_pkg::OP_SUB, 0, INT_MIN);
        send_word(sialu_pkg::OP_SUB, INT_MAX, -1);
        send_word(sialu_pkg::OP_MUL, INT_MAX, INT_MAX);
        send_word(sialu_pkg::OP_MUL, INT_MIN, -1);
        send_word(sialu_pkg::OP_MUL, INT_MIN, INT_MIN);
        send_word(sialu_pkg::OP_MUL, -3, 7);
        send_word(sialu_pkg::OP_MUL, 0, -1);
        send_word(sialu_pkg::OP_MUL, -1, -1);
        send_word(sialu_pkg::OP_DIV, 100, 0);
        send_word(sialu_pkg::OP_DIV, -100, 0);
        send_word(sialu_pkg::OP_DIV, 0, 0);
        send_word(sialu_pkg::OP_DIV, INT_MIN, 0);
        send_word(sialu_pkg::OP_DIV, INT_MIN, -1);
        send_word(sialu_pkg::OP_DIV, INT_MIN, 1);
        send_word(sialu_pkg::OP_DIV, -7, 2);
        send_word(sialu_pkg::OP_DIV, 7, -2);
        send_word(sialu_pkg::OP_DIV, -7, -2);
        send_word(sialu_pkg::OP_DIV, 5, 7);
        send_word(sialu_pkg::OP_DIV, INT_MAX, INT_MIN);
        send_word(sialu_pkg::OP_DIV, INT_MIN, INT_MIN);

        // Phase one: sender idles 38%, receiver 65%. Midway, hold off the
        // receiver for a long stretch while words keep coming.
        send_random_words(150);
        hold_request = 1'b1;
        send_random_words(270);
        wait_for_drain();

        // Phase two: roles swapped. Midway, pause the sender until drained.
        send_idle_pct = 65;
        recv_idle_pct = 38;
        send_random_words(200);
        wait_for_drain();
        send_random_words(220);
        wait_for_drain();

        // Phase three: no idling on either side, back-to-back words.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random_words(410);

        // Flush: wait for the last words, then keep clocking to catch strays.
        wait_for_drain();
        repeat (FLUSH_CYCLES) @(posedge aclk);
        if (ledger.error_count == 0 && ledger.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
sv/sialu_pkg.sv
sv/sialu_dp.sv
sv/sialu_ctrl.sv
sv/signed_integer_alu_mul_div.sv
test/testbench.sv
